FILE: rtl/vtp_pkg.sv
package vtp_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int ACC_W      = 2 * DATA_WIDTH + 3;
	localparam int NUM_W      = DATA_WIDTH + FRAC_BITS;
	localparam int REM_W      = DATA_WIDTH + 1;
	localparam int DIV_STEPS  = 2;
	localparam int DIV_STAGES = NUM_W / DIV_STEPS;
	localparam int MAT_N      = 16;

	localparam logic [1:0] CMD_LOAD   = 2'd0;
	localparam logic [1:0] CMD_LINEAR = 2'd1;
	localparam logic [1:0] CMD_PROJ   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef logic signed [DATA_WIDTH-1:0] data_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic [NUM_W-1:0] num;
		logic [REM_W-1:0] rem;
	} div_lane_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] den;
		div_lane_t lx;
		div_lane_t ly;
		div_lane_t lz;
		data_t x;
		data_t y;
		data_t z;
		logic neg_x;
		logic neg_y;
		logic neg_z;
		logic divide;
		logic wz;
		logic sat;
	} div_item_t;

	// One restoring division step; quotient bits shift in at the bottom of num.
	function automatic div_lane_t div_step(div_lane_t a, logic [DATA_WIDTH-1:0] d);
		div_lane_t r;
		logic [REM_W-1:0] rem2;
		logic [REM_W-1:0] dext;
		logic qbit;
		dext = {1'b0, d};
		rem2 = {a.rem[REM_W-2:0], a.num[NUM_W-1]};
		qbit = (rem2 >= dext);
		r.rem = qbit ? rem2 - dext : rem2;
		r.num = {a.num[NUM_W-2:0], qbit};
		return r;
	endfunction

	// Rounds a sum back to the data format; the top bit is the clamp flag.
	function automatic logic [DATA_WIDTH:0] round_sat(acc_t acc);
		acc_t sr;
		logic [ACC_W-DATA_WIDTH:0] hi;
		sr = acc >>> FRAC_BITS;
		hi = sr[ACC_W-1:DATA_WIDTH-1];
		if ((&hi) || !(|hi))
			return {1'b0, sr[DATA_WIDTH-1:0]};
		else if (sr[ACC_W-1])
			return {1'b1, DMIN};
		else
			return {1'b1, DMAX};
	endfunction

	// Applies the sign to a quotient magnitude and clamps it.
	function automatic logic [DATA_WIDTH:0] quot_sat(logic [NUM_W-1:0] q, logic neg);
		if (neg) begin
			if (q > {{FRAC_BITS{1'b0}}, DMIN})
				return {1'b1, DMIN};
			else
				return {1'b0, -q[DATA_WIDTH-1:0]};
		end else begin
			if (q > {{FRAC_BITS{1'b0}}, DMAX})
				return {1'b1, DMAX};
			else
				return {1'b0, q[DATA_WIDTH-1:0]};
		end
	endfunction

endpackage

FILE: rtl/vtp_divpipe.sv
module vtp_divpipe import vtp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_item_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output div_item_t out_data
);

	div_item_t pipe_q [DIV_STAGES];
	logic [DIV_STAGES-1:0] valid_q;
	logic [DIV_STAGES-1:0] en;
	div_item_t nxt [DIV_STAGES];

	always_comb begin
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			if (k == DIV_STAGES - 1)
				en[k] = !valid_q[k] || out_ready;
			else
				en[k] = !valid_q[k] || en[k+1];
		end
	end

	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			nxt[k] = (k == 0) ? in_data : pipe_q[k-1];
			for (int s = 0; s < DIV_STEPS; s++) begin
				nxt[k].lx = div_step(nxt[k].lx, nxt[k].den);
				nxt[k].ly = div_step(nxt[k].ly, nxt[k].den);
				nxt[k].lz = div_step(nxt[k].lz, nxt[k].den);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (en[k])
					valid_q[k] <= (k == 0) ? in_valid : valid_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (en[k])
				pipe_q[k] <= nxt[k];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_q[DIV_STAGES-1];
	assign out_data  = pipe_q[DIV_STAGES-1];

endmodule

FILE: rtl/vertex_transform_projective.sv
// An accepted transform item passes through 3 arithmetic stages, 24 divider stages
// of two quotient bits each and one output register on its way to the result.
// Throughput: one item per cycle unless the output stalls; load and unused items give no result.
// Reset clears every valid bit and the matrix to zero, asynchronously.
module vertex_transform_projective import vtp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            cmd,
	input  logic [3:0]            entry_index,
	input  logic signed [DATA_WIDTH-1:0] entry_value,
	input  logic signed [DATA_WIDTH-1:0] in_x,
	input  logic signed [DATA_WIDTH-1:0] in_y,
	input  logic signed [DATA_WIDTH-1:0] in_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [DATA_WIDTH-1:0] out_x,
	output logic signed [DATA_WIDTH-1:0] out_y,
	output logic signed [DATA_WIDTH-1:0] out_z,
	output logic                  w_was_zero,
	output logic                  saturated
);

	data_t m_q [MAT_N];

	logic signed [2*DATA_WIDTH-1:0] prod [4][3];
	logic signed [2*DATA_WIDTH-1:0] prod_s1 [4][3];
	data_t trans_s1 [4];
	logic proj_s1, v_s1;

	acc_t acc_s2 [4];
	logic proj_s2, v_s2;

	logic [DATA_WIDTH:0] rs [4];
	data_t val_s3 [4];
	logic proj_s3, sat_s3, v_s3;

	logic en1, en2, en3, en_o;
	logic div_in_ready, div_out_valid;
	div_item_t div_in, div_out;
	logic [DATA_WIDTH:0] qx, qy, qz;
	logic [DATA_WIDTH-1:0] wmag;
	logic accept, is_xform;

	assign en_o = !out_valid || out_ready;
	assign en3  = !v_s3 || div_in_ready;
	assign en2  = !v_s2 || en3;
	assign en1  = !v_s1 || en2;
	assign in_ready = en1;
	assign accept   = in_valid && in_ready;
	assign is_xform = (cmd == CMD_LINEAR) || (cmd == CMD_PROJ);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_N; i++)
				m_q[i] <= '0;
		end else if (accept && cmd == CMD_LOAD) begin
			m_q[entry_index] <= entry_value;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			prod[r][0] = m_q[r] * in_x;
			prod[r][1] = m_q[r + 4] * in_y;
			prod[r][2] = m_q[r + 8] * in_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en1) v_s1 <= accept && is_xform;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en_o) out_valid <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			prod_s1 <= prod;
			for (int r = 0; r < 4; r++)
				trans_s1[r] <= m_q[r + 12];
			proj_s1 <= (cmd == CMD_PROJ);
		end
	end

	always_ff @(posedge clk) begin
		acc_t t;
		if (en2) begin
			for (int r = 0; r < 4; r++) begin
				t = proj_s1 ? (acc_t'(trans_s1[r]) <<< FRAC_BITS) : '0;
				acc_s2[r] <= acc_t'(prod_s1[r][0]) + acc_t'(prod_s1[r][1])
					+ acc_t'(prod_s1[r][2]) + t
					+ (acc_t'(1) <<< (FRAC_BITS - 1));
			end
			proj_s2 <= proj_s1;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++)
			rs[r] = round_sat(acc_s2[r]);
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			for (int r = 0; r < 4; r++)
				val_s3[r] <= rs[r][DATA_WIDTH-1:0];
			sat_s3  <= rs[0][DATA_WIDTH] || rs[1][DATA_WIDTH] || rs[2][DATA_WIDTH]
				|| (proj_s2 && rs[3][DATA_WIDTH]);
			proj_s3 <= proj_s2;
		end
	end

	always_comb begin
		logic [DATA_WIDTH-1:0] mx, my, mz;
		wmag = val_s3[3][DATA_WIDTH-1] ? -val_s3[3] : val_s3[3];
		mx   = val_s3[0][DATA_WIDTH-1] ? -val_s3[0] : val_s3[0];
		my   = val_s3[1][DATA_WIDTH-1] ? -val_s3[1] : val_s3[1];
		mz   = val_s3[2][DATA_WIDTH-1] ? -val_s3[2] : val_s3[2];
		div_in.den    = wmag;
		div_in.lx     = '{num: {mx, {FRAC_BITS{1'b0}}}, rem: '0};
		div_in.ly     = '{num: {my, {FRAC_BITS{1'b0}}}, rem: '0};
		div_in.lz     = '{num: {mz, {FRAC_BITS{1'b0}}}, rem: '0};
		div_in.x      = val_s3[0];
		div_in.y      = val_s3[1];
		div_in.z      = val_s3[2];
		div_in.neg_x  = val_s3[0][DATA_WIDTH-1] ^ val_s3[3][DATA_WIDTH-1];
		div_in.neg_y  = val_s3[1][DATA_WIDTH-1] ^ val_s3[3][DATA_WIDTH-1];
		div_in.neg_z  = val_s3[2][DATA_WIDTH-1] ^ val_s3[3][DATA_WIDTH-1];
		div_in.wz     = proj_s3 && (val_s3[3] == '0);
		div_in.divide = proj_s3 && (val_s3[3] != '0);
		div_in.sat    = sat_s3;
	end

	vtp_divpipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (div_in_ready),
		.in_data   (div_in),
		.out_valid (div_out_valid),
		.out_ready (en_o),
		.out_data  (div_out)
	);

	assign qx = quot_sat(div_out.lx.num, div_out.neg_x);
	assign qy = quot_sat(div_out.ly.num, div_out.neg_y);
	assign qz = quot_sat(div_out.lz.num, div_out.neg_z);

	always_ff @(posedge clk) begin
		if (en_o) begin
			out_x      <= div_out.divide ? qx[DATA_WIDTH-1:0] : div_out.x;
			out_y      <= div_out.divide ? qy[DATA_WIDTH-1:0] : div_out.y;
			out_z      <= div_out.divide ? qz[DATA_WIDTH-1:0] : div_out.z;
			w_was_zero <= div_out.wz;
			saturated  <= div_out.sat || (div_out.divide
				&& (qx[DATA_WIDTH] || qy[DATA_WIDTH] || qz[DATA_WIDTH]));
		end
	end

endmodule

FILE: rtl/vtp_checker.sv
module vtp_checker import vtp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic signed [DATA_WIDTH-1:0] out_x
);

	// An empty output register leaves the whole pipeline free to move.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("input stalled with empty output");

	// A transfer at the output frees a slot all the way back to the input.
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |-> in_ready) else $error("input stalled on transfer");

	a_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid) else $error("result right after reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_x)))
		else $error("stalled result changed");

endmodule

bind vertex_transform_projective vtp_checker u_vtp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_x     (out_x)
);

FILE: dv/vertex_transform_projective_test.sv
`timescale 1ns / 1ps

module vertex_transform_projective_test;
	import vtp_pkg::*;

	typedef struct {
		logic [1:0] cmd;
		logic [3:0] idx;
		logic signed [31:0] val;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} vertex_item_t;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic wz;
		logic sat;
	} point_result_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [1:0] cmd;
	logic [3:0] entry_index;
	logic signed [31:0] entry_value;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic w_was_zero;
	logic saturated;

	vertex_item_t pending_items[$];
	point_result_t expected_points[$];
	logic signed [31:0] matrix_copy[16];
	int mismatches;
	int burst_left;
	int gap_left;
	int stall_phase;
	bit hold_sender;
	bit in_taken;

	vertex_transform_projective uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .entry_index(entry_index), .entry_value(entry_value),
		.in_x(in_x), .in_y(in_y), .in_z(in_z), .out_valid(out_valid),
		.out_ready(out_ready), .out_x(out_x), .out_y(out_y), .out_z(out_z),
		.w_was_zero(w_was_zero), .saturated(saturated)
	);

	function automatic logic signed [31:0] clamp_wide(logic signed [127:0] v, ref bit sat);
		if (v > 128'sd2147483647) begin
			sat = 1;
			return 32'sh7fffffff;
		end
		if (v < -128'sd2147483648) begin
			sat = 1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] row_sum(int r, vertex_item_t it, bit trans,
		ref bit sat);
		logic signed [127:0] acc;
		acc = 128'(matrix_copy[r]) * 128'(it.x) + 128'(matrix_copy[r + 4]) * 128'(it.y)
			+ 128'(matrix_copy[r + 8]) * 128'(it.z);
		if (trans)
			acc = acc + (128'(matrix_copy[r + 12]) <<< 16);
		acc = (acc + 128'sd32768) >>> 16;
		return clamp_wide(acc, sat);
	endfunction

	function automatic logic signed [31:0] fixed_divide(logic signed [31:0] n,
		logic signed [31:0] d, ref bit sat);
		logic signed [127:0] q;
		q = (128'(n) <<< 16) / 128'(d);
		return clamp_wide(q, sat);
	endfunction

	function automatic bit transform_vertex(vertex_item_t it, output point_result_t res);
		bit sat;
		logic signed [31:0] w;
		sat = 0;
		res.wz = 0;
		if (it.cmd == CMD_LOAD) begin
			matrix_copy[it.idx] = it.val;
			return 0;
		end
		if (it.cmd != CMD_LINEAR && it.cmd != CMD_PROJ)
			return 0;
		res.x = row_sum(0, it, it.cmd == CMD_PROJ, sat);
		res.y = row_sum(1, it, it.cmd == CMD_PROJ, sat);
		res.z = row_sum(2, it, it.cmd == CMD_PROJ, sat);
		if (it.cmd == CMD_PROJ) begin
			w = row_sum(3, it, 1, sat);
			if (w == 0) begin
				res.wz = 1;
			end else begin
				res.x = fixed_divide(res.x, w, sat);
				res.y = fixed_divide(res.y, w, sat);
				res.z = fixed_divide(res.z, w, sat);
			end
		end
		res.sat = sat;
		return 1;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'sh7fffffff;
			2: return 32'sh80000000;
			3: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
			default: return $signed($urandom_range(0, 32'h7ffffff)) - 32'sh4000000;
		endcase
	endfunction

	task automatic add_item(logic [1:0] c, logic [3:0] i, logic signed [31:0] v,
		logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
		vertex_item_t it;
		it.cmd = c;
		it.idx = i;
		it.val = v;
		it.x = x;
		it.y = y;
		it.z = z;
		pending_items.push_back(it);
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50_000_000;
		$display("[vertex_transform_projective] ERROR");
		$finish;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_taken) begin
			if (hold_sender || pending_items.size() == 0) begin
				in_valid <= 0;
			end else if (gap_left > 0) begin
				in_valid <= 0;
				gap_left <= gap_left - 1;
			end else begin
				cmd <= pending_items[0].cmd;
				entry_index <= pending_items[0].idx;
				entry_value <= pending_items[0].val;
				in_x <= pending_items[0].x;
				in_y <= pending_items[0].y;
				in_z <= pending_items[0].z;
				in_valid <= 1;
				void'(pending_items.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if ((stall_phase / 200) % 3 == 0)
			out_ready <= 1;
		else
			out_ready <= ($urandom_range(0, 3) != 0) && ((stall_phase % 11) != 3);
	end

	always @(posedge clk) begin
		point_result_t res;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			vertex_item_t it;
			it.cmd = cmd;
			it.idx = entry_index;
			it.val = entry_value;
			it.x = in_x;
			it.y = in_y;
			it.z = in_z;
			if (transform_vertex(it, res))
				expected_points.push_back(res);
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				mismatches = mismatches + 1;
				if (mismatches <= 10)
					$display("Unexpected result transfer: %h %h %h", out_x, out_y, out_z);
			end else begin
				res = expected_points.pop_front();
				if (out_x !== res.x || out_y !== res.y || out_z !== res.z
					|| w_was_zero !== res.wz || saturated !== res.sat) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("Mismatch: expected %h %h %h wz=%b sat=%b, got %h %h %h wz=%b sat=%b",
							res.x, res.y, res.z, res.wz, res.sat,
							out_x, out_y, out_z, w_was_zero, saturated);
				end
			end
		end
	end

	initial begin
		logic [1:0] c;
		int idle;
		mismatches = 0;
		stall_phase = 0;
		hold_sender = 0;
		out_ready = 0;
		in_valid = 0;
		cmd = CMD_LOAD;
		entry_index = 0;
		entry_value = 0;
		in_x = 0;
		in_y = 0;
		in_z = 0;
		for (int i = 0; i < 16; i++)
			matrix_copy[i] = 0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		add_item(CMD_LINEAR, 0, 0, 32'sh7fffffff, 32'sh80000000, 32'sh10000);
		add_item(CMD_PROJ, 0, 0, 32'sh10000, 32'sh20000, 32'sh30000);
		add_item(CMD_UNUSED, 5, 32'sh1234, 1, 2, 3);
		for (int i = 0; i < 16; i++)
			add_item(CMD_LOAD, 4'(i), (i % 5 == 0) ? 32'sh10000 : 32'sh800 * i, 0, 0, 0);
		add_item(CMD_LINEAR, 4'hf, 32'shffffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh7fffffff);
		add_item(CMD_PROJ, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		add_item(CMD_PROJ, 0, 0, 32'sh30000, 32'shfffe0000, 32'sh1);
		add_item(CMD_LOAD, 15, 0, 0, 0, 0);
		add_item(CMD_LOAD, 3, 0, 0, 0, 0);
		add_item(CMD_LOAD, 7, 0, 0, 0, 0);
		add_item(CMD_LOAD, 11, 1, 0, 0, 0);
		add_item(CMD_PROJ, 0, 0, 32'sh10000, 32'sh10000, 32'sh1);
		add_item(CMD_PROJ, 0, 0, 32'sh10000, 32'sh10000, 32'sh7fff0000);

		for (int n = 0; n < 1350; n++) begin
			if (n == 600) begin
				wait (pending_items.size() == 0 && expected_points.size() == 0);
				hold_sender = 1;
				repeat (40) @(posedge clk);
				hold_sender = 0;
			end
			case ($urandom_range(0, 19))
				0, 1, 2: c = CMD_LOAD;
				3: c = CMD_UNUSED;
				4, 5, 6, 7, 8, 9: c = CMD_LINEAR;
				default: c = CMD_PROJ;
			endcase
			if (c == CMD_LOAD && $urandom_range(0, 3) == 0)
				add_item(c, 4'($urandom_range(0, 3) * 4 + 3),
					($urandom_range(0, 2) == 0) ? 32'sh0 : rand_coord(),
					$urandom, $urandom, $urandom);
			else
				add_item(c, 4'($urandom), rand_coord(), rand_coord(), rand_coord(),
					rand_coord());
			if (pending_items.size() > 50)
				wait (pending_items.size() < 10);
		end
		wait (pending_items.size() == 0);
		idle = 0;
		while (idle < 100) begin
			@(posedge clk);
			if (expected_points.size() == 0 && !in_valid)
				idle = idle + 1;
			else
				idle = 0;
		end
		if (mismatches == 0 && expected_points.size() == 0)
			$display("[vertex_transform_projective] OK");
		else
			$display("[vertex_transform_projective] ERROR");
		$finish;
	end

endmodule

FILE: files.f
rtl/vtp_pkg.sv
rtl/vtp_divpipe.sv
rtl/vertex_transform_projective.sv
rtl/vtp_checker.sv
dv/vertex_transform_projective_test.sv
